[src/prd_pkg.sv]
// ----------------------------------------------------------------------------
// prd_pkg: primary ray direction constants
// Field widths, register indexes and reset values of the ray direction unit.
// ----------------------------------------------------------------------------
package prd_pkg;

  localparam int DIM_BITS      = 13;  // image width and height
  localparam int RATIO_BITS    = 24;  // aspect ratio, unsigned Q8.16
  localparam int RATIO_FRAC    = 16;
  localparam int VEC_BITS      = 21;  // one packed camera vector component
  localparam int VEC_PACK_BITS = 3 * VEC_BITS;
  localparam int AMT_INT_BITS  = 7;   // integer bits of the screen amounts
  localparam int NORM_BITS     = 30;  // magnitudes after normalisation

  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = VEC_PACK_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_WIDTH    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_IMAGE_HEIGHT   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ASPECT_RATIO   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RIGHT_VECTOR   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DOWN_VECTOR    = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_FORWARD_VECTOR = 3'd5;

  localparam logic [DIM_BITS-1:0]   RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [DIM_BITS-1:0]   RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [RATIO_BITS-1:0] RST_ASPECT_RATIO = 24'd87381;

endpackage

[src/primary_ray_direction_unit.sv]
// ----------------------------------------------------------------------------
// primary_ray_direction_unit: pinhole camera primary ray direction
// Maps a pixel coordinate to the unit direction through the pixel centre.
// ----------------------------------------------------------------------------
//  channel  handshake                  payload
//  in       in_valid / in_stall        pixel_x, pixel_y
//  out      out_valid / out_stall      dir_x, dir_y, dir_z (signed Q1.FRAC)
//  cfg      cfg_wr_en                  cfg_index, cfg_data
//
// One pixel enters per cycle while in_stall is low; the pipeline is formed by
// the bit-per-stage screen amount divider, the 31 stage square root and
// the bit-per-stage final divider. Synchronous reset empties the pipeline and
// loads the register defaults. The pipeline halts only once the output skid
// register is full, so one result may wait without stalling the input.
// ----------------------------------------------------------------------------
module primary_ray_direction_unit
  import prd_pkg::*;
#(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 18
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [COORD_BITS-1:0]           pixel_x,
  input  logic [COORD_BITS-1:0]           pixel_y,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [FRAC_BITS+1:0]     dir_x,
  output logic signed [FRAC_BITS+1:0]     dir_y,
  output logic signed [FRAC_BITS+1:0]     dir_z,
  input  logic                            cfg_wr_en,
  input  logic [CFG_IDX_BITS-1:0]         cfg_index,
  input  logic [CFG_DATA_BITS-1:0]        cfg_data
);

  localparam int P1W   = COORD_BITS + 1 + DIM_BITS;     // (2x+1)*h
  localparam int P2W   = P1W + RATIO_BITS;              // times ratio
  localparam int WHW   = 2 * DIM_BITS;
  localparam int DD_SH = RATIO_FRAC + AMT_INT_BITS;
  localparam int RAW   = WHW + DD_SH + 1;
  localparam int SATW  = (P2W > RAW) ? P2W : RAW;
  localparam int BMW   = ((COORD_BITS + 1 > DIM_BITS) ? COORD_BITS + 1 : DIM_BITS) + 1;
  localparam int RBW   = DIM_BITS + AMT_INT_BITS + 1;
  localparam int SBW   = (BMW > RBW) ? BMW : RBW;
  localparam int NQ    = AMT_INT_BITS + FRAC_BITS + 1;  // quotient bits
  localparam int PW    = NQ + VEC_BITS;
  localparam int MW    = NQ + VEC_BITS;                 // sum magnitude
  localparam int SW    = MW + 1;
  localparam int NS    = $clog2(MW);
  localparam int SUMW  = 2 * NORM_BITS + 2;
  localparam int SQI   = SUMW / 2;
  localparam int LW    = SQI;
  localparam int RLW   = LW + FRAC_BITS + 1;
  localparam int FQ    = FRAC_BITS + 1;
  localparam int OW    = FRAC_BITS + 2;

  localparam logic [SUMW:0] SQ_ONE = 1;

  // configuration registers
  logic [DIM_BITS-1:0]      image_width;
  logic [DIM_BITS-1:0]      image_height;
  logic [RATIO_BITS-1:0]    aspect_ratio;
  logic [VEC_PACK_BITS-1:0] right_vector;
  logic [VEC_PACK_BITS-1:0] down_vector;
  logic [VEC_PACK_BITS-1:0] forward_vector;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= RST_IMAGE_WIDTH;
      image_height   <= RST_IMAGE_HEIGHT;
      aspect_ratio   <= RST_ASPECT_RATIO;
      right_vector   <= '0;
      down_vector    <= '0;
      forward_vector <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:    image_width    <= cfg_data[DIM_BITS-1:0];
        CFG_IMAGE_HEIGHT:   image_height   <= cfg_data[DIM_BITS-1:0];
        CFG_ASPECT_RATIO:   aspect_ratio   <= cfg_data[RATIO_BITS-1:0];
        CFG_RIGHT_VECTOR:   right_vector   <= cfg_data;
        CFG_DOWN_VECTOR:    down_vector    <= cfg_data;
        CFG_FORWARD_VECTOR: forward_vector <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero dimensions count as one
  logic [DIM_BITS-1:0] w_eff, h_eff;
  logic [WHW-1:0]      ww_q, wh_q;
  assign w_eff = (image_width  == '0) ? DIM_BITS'(1) : image_width;
  assign h_eff = (image_height == '0) ? DIM_BITS'(1) : image_height;

  always_ff @(posedge clk) begin
    ww_q <= WHW'(w_eff) * WHW'(w_eff);
    wh_q <= WHW'(w_eff) * WHW'(h_eff);
  end

  logic adv;
  logic skid_full;
  assign adv      = !skid_full;
  assign in_stall = skid_full;

  // ---------------- front: amounts' numerators ----------------
  logic                  v0, v1, v2;
  logic [COORD_BITS-1:0] x0, y0;
  logic [P1W-1:0]        p1;
  logic [P2W-1:0]        p2;
  logic [BMW-1:0]        bmag1, bmag2;
  logic                  bneg1, bneg2;
  logic [BMW-1:0]        b_pos, b_twoy;
  logic [P2W-1:0]        ww16;

  assign b_pos  = BMW'(h_eff) + BMW'(1);
  assign b_twoy = BMW'({y0, 1'b0});
  assign ww16   = P2W'({ww_q, {RATIO_FRAC{1'b0}}});

  // screen amount dividers, one quotient bit per stage
  logic            dv_v  [NQ+1];
  logic [RAW-1:0]  dv_ra [NQ+1];
  logic [RBW-1:0]  dv_rb [NQ+1];
  logic [NQ-1:0]   dv_qa [NQ+1];
  logic [NQ-1:0]   dv_qb [NQ+1];
  logic            dv_sa [NQ+1];
  logic            dv_sb [NQ+1];
  logic            dv_na [NQ+1];
  logic            dv_nb [NQ+1];
  logic [RAW-1:0]  dd_a;
  logic [RBW-1:0]  dd_b;
  logic [P2W-1:0]  amag;
  logic            aneg;

  assign dd_a = RAW'({wh_q, {DD_SH{1'b0}}});
  assign dd_b = RBW'({h_eff, {AMT_INT_BITS{1'b0}}});
  assign aneg = p2 < ww16;
  assign amag = aneg ? (ww16 - p2) : (p2 - ww16);

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      for (int i = 0; i <= NQ; i++) dv_v[i] <= 1'b0;
    end else if (adv) begin
      v0 <= in_valid;
      x0 <= pixel_x;
      y0 <= pixel_y;

      v1    <= v0;
      p1    <= P1W'({x0, 1'b1}) * P1W'(h_eff);
      bneg1 <= b_twoy > b_pos;
      bmag1 <= (b_twoy > b_pos) ? (b_twoy - b_pos) : (b_pos - b_twoy);

      v2    <= v1;
      p2    <= P2W'(p1) * P2W'(aspect_ratio);
      bneg2 <= bneg1;
      bmag2 <= bmag1;

      dv_v[0]  <= v2;
      dv_na[0] <= aneg;
      dv_nb[0] <= bneg2;
      dv_sa[0] <= SATW'(amag) >= SATW'({wh_q, {(DD_SH + 1){1'b0}}});
      dv_sb[0] <= SBW'(bmag2) >= SBW'({h_eff, {(AMT_INT_BITS + 1){1'b0}}});
      dv_ra[0] <= RAW'(amag);
      dv_rb[0] <= RBW'(bmag2);
      dv_qa[0] <= '0;
      dv_qb[0] <= '0;

      for (int i = 0; i < NQ; i++) begin
        dv_v[i+1]  <= dv_v[i];
        dv_na[i+1] <= dv_na[i];
        dv_nb[i+1] <= dv_nb[i];
        dv_sa[i+1] <= dv_sa[i];
        dv_sb[i+1] <= dv_sb[i];
        dv_ra[i+1] <= (dv_ra[i] >= dd_a) ? ((dv_ra[i] - dd_a) << 1) : (dv_ra[i] << 1);
        dv_rb[i+1] <= (dv_rb[i] >= dd_b) ? ((dv_rb[i] - dd_b) << 1) : (dv_rb[i] << 1);
        dv_qa[i+1] <= {dv_qa[i][NQ-2:0], dv_ra[i] >= dd_a};
        dv_qb[i+1] <= {dv_qb[i][NQ-2:0], dv_rb[i] >= dd_b};
      end
    end
  end

  // ---------------- rounding, weighting and sums ----------------
  logic [NQ:0]   qa1, qb1;
  logic [NQ-1:0] resa, resb, lim;
  logic [NQ-1:0] a_fix, b_fix;

  assign lim = {1'b0, {(NQ-1){1'b1}}};
  assign qa1 = {1'b0, dv_qa[NQ]} + (NQ+1)'(1);
  assign qb1 = {1'b0, dv_qb[NQ]} + (NQ+1)'(1);

  always_comb begin
    resa = (dv_sa[NQ] || qa1[NQ:1] > lim) ? lim : qa1[NQ:1];
    resb = (dv_sb[NQ] || qb1[NQ:1] > lim) ? lim : qb1[NQ:1];
    a_fix = dv_na[NQ] ? -resa : resa;
    b_fix = dv_nb[NQ] ? -resb : resb;
  end

  logic                 rv, mv, sv, av;
  logic signed [NQ-1:0] a_q, b_q;
  logic signed [PW-1:0] pr [3];
  logic signed [PW-1:0] pd [3];
  logic signed [SW-1:0] s  [3];
  logic [MW-1:0]        ab_m [3];
  logic                 ab_n [3];

  // normaliser, one shift step per stage
  logic          nz_v    [NS+1];
  logic [MW-1:0] nz_m    [NS+1][3];
  logic [MW-1:0] nz_mx   [NS+1];
  logic          nz_n    [NS+1][3];
  logic          nz_zero [NS+1];
  logic [MW-1:0] mx01;

  assign mx01 = (ab_m[1] > ab_m[0]) ? ab_m[1] : ab_m[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
      mv <= 1'b0;
      sv <= 1'b0;
      av <= 1'b0;
      for (int j = 0; j <= NS; j++) nz_v[j] <= 1'b0;
    end else if (adv) begin
      rv  <= dv_v[NQ];
      a_q <= $signed(a_fix);
      b_q <= $signed(b_fix);

      mv <= rv;
      for (int c = 0; c < 3; c++) begin
        pr[c] <= PW'(a_q) * PW'($signed(right_vector[VEC_BITS*c +: VEC_BITS]));
        pd[c] <= PW'(b_q) * PW'($signed(down_vector[VEC_BITS*c +: VEC_BITS]));
      end

      sv <= mv;
      for (int c = 0; c < 3; c++) begin
        s[c] <= SW'(pr[c]) + SW'(pd[c])
              + (SW'($signed(forward_vector[VEC_BITS*c +: VEC_BITS])) <<< FRAC_BITS);
      end

      av <= sv;
      for (int c = 0; c < 3; c++) begin
        ab_n[c] <= s[c][SW-1];
        ab_m[c] <= s[c][SW-1] ? MW'(-s[c]) : MW'(s[c]);
      end

      nz_v[0]    <= av;
      nz_mx[0]   <= (ab_m[2] > mx01) ? ab_m[2] : mx01;
      nz_zero[0] <= (ab_m[0] == '0) && (ab_m[1] == '0) && (ab_m[2] == '0);
      for (int c = 0; c < 3; c++) begin
        nz_m[0][c] <= ab_m[c];
        nz_n[0][c] <= ab_n[c];
      end

      for (int j = 0; j < NS; j++) begin
        nz_v[j+1]    <= nz_v[j];
        nz_zero[j+1] <= nz_zero[j];
        for (int c = 0; c < 3; c++) nz_n[j+1][c] <= nz_n[j][c];
        if ((nz_mx[j] >> (MW - (1 << (NS - 1 - j)))) == '0) begin
          nz_mx[j+1] <= nz_mx[j] << (1 << (NS - 1 - j));
          for (int c = 0; c < 3; c++) nz_m[j+1][c] <= nz_m[j][c] << (1 << (NS - 1 - j));
        end else begin
          nz_mx[j+1] <= nz_mx[j];
          for (int c = 0; c < 3; c++) nz_m[j+1][c] <= nz_m[j][c];
        end
      end
    end
  end

  // ---------------- length: squares and square root ----------------
  logic                   qv;
  logic [2*NORM_BITS-1:0] sqr [3];
  logic [NORM_BITS-1:0]   qm  [3];
  logic                   qn  [3];
  logic                   qz;

  logic                 sq_v    [SQI+1];
  logic [SUMW-1:0]      sq_n    [SQI+1];
  logic [SUMW:0]        sq_res  [SQI+1];
  logic [NORM_BITS-1:0] sq_m    [SQI+1][3];
  logic                 sq_ng   [SQI+1][3];
  logic                 sq_zero [SQI+1];

  logic [SUMW:0]   sq_bit    [SQI];
  logic [SUMW:0]   sq_trial  [SQI];
  logic [SUMW:0]   sq_rem    [SQI];
  logic [SUMW-1:0] sq_n_nx   [SQI];
  logic [SUMW:0]   sq_res_nx [SQI];

  always_comb begin
    for (int i = 0; i < SQI; i++) begin
      sq_bit[i]   = SQ_ONE << (SUMW - 2 - 2 * i);
      sq_trial[i] = sq_res[i] + sq_bit[i];
      sq_rem[i]   = {1'b0, sq_n[i]} - sq_trial[i];
      if ({1'b0, sq_n[i]} >= sq_trial[i]) begin
        sq_n_nx[i]   = sq_rem[i][SUMW-1:0];
        sq_res_nx[i] = (sq_res[i] >> 1) + sq_bit[i];
      end else begin
        sq_n_nx[i]   = sq_n[i];
        sq_res_nx[i] = sq_res[i] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qv <= 1'b0;
      for (int i = 0; i <= SQI; i++) sq_v[i] <= 1'b0;
    end else if (adv) begin
      qv <= nz_v[NS];
      qz <= nz_zero[NS];
      for (int c = 0; c < 3; c++) begin
        qm[c]  <= nz_m[NS][c][MW-1 -: NORM_BITS];
        qn[c]  <= nz_n[NS][c];
        sqr[c] <= (2*NORM_BITS)'(nz_m[NS][c][MW-1 -: NORM_BITS])
                * (2*NORM_BITS)'(nz_m[NS][c][MW-1 -: NORM_BITS]);
      end

      sq_v[0]    <= qv;
      sq_zero[0] <= qz;
      sq_n[0]    <= SUMW'(sqr[0]) + SUMW'(sqr[1]) + SUMW'(sqr[2]);
      sq_res[0]  <= '0;
      for (int c = 0; c < 3; c++) begin
        sq_m[0][c]  <= qm[c];
        sq_ng[0][c] <= qn[c];
      end

      for (int i = 0; i < SQI; i++) begin
        sq_v[i+1]    <= sq_v[i];
        sq_zero[i+1] <= sq_zero[i];
        sq_n[i+1]    <= sq_n_nx[i];
        sq_res[i+1]  <= sq_res_nx[i];
        for (int c = 0; c < 3; c++) begin
          sq_m[i+1][c]  <= sq_m[i][c];
          sq_ng[i+1][c] <= sq_ng[i][c];
        end
      end
    end
  end

  // ---------------- component / length, one bit per stage ----------------
  logic           fd_v    [FQ+1];
  logic [LW-1:0]  fd_l    [FQ+1];
  logic [RLW-1:0] fd_r    [FQ+1][3];
  logic [FQ-1:0]  fd_q    [FQ+1][3];
  logic           fd_ng   [FQ+1][3];
  logic           fd_zero [FQ+1];
  logic [LW-1:0]  len;
  logic [RLW-1:0] fd_dd   [FQ];

  assign len = sq_res[SQI][LW-1:0];

  always_comb begin
    for (int i = 0; i < FQ; i++) fd_dd[i] = RLW'({fd_l[i], {FRAC_BITS{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= FQ; i++) fd_v[i] <= 1'b0;
    end else if (adv) begin
      fd_v[0]    <= sq_v[SQI];
      fd_zero[0] <= sq_zero[SQI];
      fd_l[0]    <= len;
      for (int c = 0; c < 3; c++) begin
        fd_ng[0][c] <= sq_ng[SQI][c];
        fd_q[0][c]  <= '0;
        fd_r[0][c]  <= RLW'({sq_m[SQI][c], {FRAC_BITS{1'b0}}}) + RLW'(len >> 1);
      end

      for (int i = 0; i < FQ; i++) begin
        fd_v[i+1]    <= fd_v[i];
        fd_zero[i+1] <= fd_zero[i];
        fd_l[i+1]    <= fd_l[i];
        for (int c = 0; c < 3; c++) begin
          fd_ng[i+1][c] <= fd_ng[i][c];
          fd_r[i+1][c]  <= (fd_r[i][c] >= fd_dd[i]) ? ((fd_r[i][c] - fd_dd[i]) << 1)
                                                     : (fd_r[i][c] << 1);
          fd_q[i+1][c]  <= {fd_q[i][c][FQ-2:0], fd_r[i][c] >= fd_dd[i]};
        end
      end
    end
  end

  // ---------------- output register and skid ----------------
  logic [OW-1:0] dir_new  [3];
  logic [OW-1:0] dir_out  [3];
  logic [OW-1:0] dir_skid [3];
  logic          incoming, out_fire;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (fd_zero[FQ]) dir_new[c] = '0;
      else if (fd_ng[FQ][c]) dir_new[c] = -OW'(fd_q[FQ][c]);
      else dir_new[c] = OW'(fd_q[FQ][c]);
    end
  end

  assign incoming = adv && fd_v[FQ];
  assign out_fire = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      // drain the skid once the waiting result is taken
      if (out_fire) begin
        dir_out   <= dir_skid;
        skid_full <= 1'b0;
      end
    end else if (incoming) begin
      if (!out_valid || out_fire) begin
        dir_out   <= dir_new;
        out_valid <= 1'b1;
      end else begin
        dir_skid  <= dir_new;
        skid_full <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  assign dir_x = $signed(dir_out[0]);
  assign dir_y = $signed(dir_out[1]);
  assign dir_z = $signed(dir_out[2]);

endmodule
